FILE: design/ipl4hp_pkg.sv
// Shared types, codes and constants of the IPv4 and transport header parser.
package ipl4hp_pkg;

   // Packet length limit; the byte counter saturates here.
   localparam int unsigned LEN_W   = 16;
   localparam logic [LEN_W-1:0] MAX_LEN = 16'hFFFF;

   // IPv4 and transport header constants.
   localparam logic [3:0]       IP_VERSION  = 4'd4;
   localparam logic [LEN_W-1:0] IP_MIN_HDR  = 16'd20;
   localparam logic [LEN_W-1:0] TCP_MIN_HDR = 16'd20;
   localparam logic [5:0]       SMALL_HDR   = 6'd8;
   localparam logic [7:0]       PROTO_ICMP  = 8'd1;
   localparam logic [7:0]       PROTO_TCP   = 8'd6;
   localparam logic [7:0]       PROTO_UDP   = 8'd17;

   // Byte positions of the IPv4 header fields.
   localparam logic [LEN_W-1:0] POS_VER_IHL  = 16'd0;
   localparam logic [LEN_W-1:0] POS_FRAG_HI  = 16'd6;
   localparam logic [LEN_W-1:0] POS_FRAG_LO  = 16'd7;
   localparam logic [LEN_W-1:0] POS_PROTO    = 16'd9;
   localparam logic [LEN_W-1:0] POS_SRC_LO   = 16'd12;
   localparam logic [LEN_W-1:0] POS_SRC_HI   = 16'd15;
   localparam logic [LEN_W-1:0] POS_DST_LO   = 16'd16;
   localparam logic [LEN_W-1:0] POS_DST_HI   = 16'd19;

   // Byte positions inside the transport header.
   localparam logic [3:0] REL_PORT_A_LAST = 4'd1;
   localparam logic [3:0] REL_PORT_B_LAST = 4'd3;
   localparam logic [3:0] REL_SEQ_LAST    = 4'd7;
   localparam logic [3:0] REL_ACK_LAST    = 4'd11;
   localparam logic [3:0] REL_DOFF        = 4'd12;
   localparam logic [3:0] REL_FLAGS       = 4'd13;

   // Result status codes.
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_BAD_IHL     = 3'd3;
   localparam logic [2:0] STATUS_FRAGMENT    = 3'd4;
   localparam logic [2:0] STATUS_UNSUPPORTED = 3'd5;

   // Queue between the capture front and the result back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Captured header bytes of one packet; len doubles as the byte counter.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [7:0]       version_ihl;
      logic [15:0]      frag_word;
      logic [7:0]       proto;
      logic [31:0]      src_addr;
      logic [31:0]      dst_addr;
      logic [15:0]      port_a;
      logic [15:0]      port_b;
      logic [7:0]       flags;
      logic [31:0]      seq;
      logic [31:0]      ack;
      logic [3:0]       data_offset;
   } pkt_rec_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol_num;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  tcp_flag_bits;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [15:0] icmp_type_code;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
   } result_type;

   // Handshake between a producer and the queue, and the queue and a consumer.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: design/ipl4hp_front.sv
// Capture front: counts packet bytes and captures header fields at their offsets.
module ipl4hp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   input  ipl4hp_pkg::queue_status_type q_status,
   output logic                     push,
   output ipl4hp_pkg::pkt_rec_type  push_data
);

   ipl4hp_pkg::pkt_rec_type state_ff;
   ipl4hp_pkg::pkt_rec_type state_in;
   ipl4hp_pkg::pkt_rec_type cap;

   logic                            accept;
   logic                            cap_en;
   logic [ipl4hp_pkg::LEN_W-1:0]    pos;
   logic [ipl4hp_pkg::LEN_W-1:0]    hdr_len;
   logic [ipl4hp_pkg::LEN_W-1:0]    rel;
   logic                            in_xport;

   // A new byte is taken whenever a finished packet could still be queued.
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign pos     = state_ff.len;
   assign cap_en  = (pos != ipl4hp_pkg::MAX_LEN);
   assign hdr_len = ipl4hp_pkg::LEN_W'({state_ff.version_ihl[3:0], 2'b00});
   assign rel     = pos - hdr_len;
   assign in_xport = cap_en && (pos >= ipl4hp_pkg::IP_MIN_HDR) && (pos >= hdr_len) &&
                     (rel[ipl4hp_pkg::LEN_W-1:4] == '0);

   // Capture the current byte into whichever field its position selects.
   always_comb begin
      cap = state_ff;
      if (cap_en) begin
         cap.len = pos + 16'd1;
         if (pos == ipl4hp_pkg::POS_VER_IHL) begin
            cap.version_ihl = req_data_byte;
         end else if (pos == ipl4hp_pkg::POS_FRAG_HI || pos == ipl4hp_pkg::POS_FRAG_LO) begin
            cap.frag_word = {state_ff.frag_word[7:0], req_data_byte};
         end else if (pos == ipl4hp_pkg::POS_PROTO) begin
            cap.proto = req_data_byte;
         end else if (pos >= ipl4hp_pkg::POS_SRC_LO && pos <= ipl4hp_pkg::POS_SRC_HI) begin
            cap.src_addr = {state_ff.src_addr[23:0], req_data_byte};
         end else if (pos >= ipl4hp_pkg::POS_DST_LO && pos <= ipl4hp_pkg::POS_DST_HI) begin
            cap.dst_addr = {state_ff.dst_addr[23:0], req_data_byte};
         end
      end
      // Transport header bytes, counted from the end of the IPv4 header.
      if (in_xport) begin
         if (rel[3:0] <= ipl4hp_pkg::REL_PORT_A_LAST) begin
            cap.port_a = {state_ff.port_a[7:0], req_data_byte};
         end else if (rel[3:0] <= ipl4hp_pkg::REL_PORT_B_LAST) begin
            cap.port_b = {state_ff.port_b[7:0], req_data_byte};
         end else if (rel[3:0] <= ipl4hp_pkg::REL_SEQ_LAST) begin
            cap.seq = {state_ff.seq[23:0], req_data_byte};
         end else if (rel[3:0] <= ipl4hp_pkg::REL_ACK_LAST) begin
            cap.ack = {state_ff.ack[23:0], req_data_byte};
         end else if (rel[3:0] == ipl4hp_pkg::REL_DOFF) begin
            cap.data_offset = req_data_byte[7:4];
         end else if (rel[3:0] == ipl4hp_pkg::REL_FLAGS) begin
            cap.flags = req_data_byte;
         end
      end
   end

   // On the last byte the packet goes to the queue and the capture starts over.
   assign push      = accept && req_last_byte;
   assign push_data = cap;
   assign state_in  = req_last_byte ? '0 : cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/ipl4hp_queue.sv
// Short queue of captured packets between the capture front and the result back.
module ipl4hp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ipl4hp_pkg::pkt_rec_type       push_data,
   input  logic                          pop,
   output ipl4hp_pkg::pkt_rec_type       head,
   output ipl4hp_pkg::queue_status_type  q_status
);

   ipl4hp_pkg::pkt_rec_type                 mem_ff [ipl4hp_pkg::QUEUE_DEPTH];
   logic [ipl4hp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ipl4hp_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ipl4hp_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                    do_push, do_pop;

   localparam logic [ipl4hp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ipl4hp_pkg::QUEUE_PTR_W'(ipl4hp_pkg::QUEUE_DEPTH - 1);
   localparam logic [ipl4hp_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      ipl4hp_pkg::QUEUE_CNT_W'(ipl4hp_pkg::QUEUE_DEPTH);

   assign q_status.full      = (count_ff == FULL_CNT);
   assign q_status.not_empty = (count_ff != '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.not_empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A packet is never offered while the queue is full.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("queue: packet pushed while full");

   // The back only takes an entry that is present.
   assert property (@(posedge clock) disable iff (reset) pop |-> q_status.not_empty)
      else $error("queue: pop while empty");

   // The occupancy count rises by one on a push without a pop.
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !q_status.full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue: count did not advance on push");

endmodule

FILE: design/ipl4hp_back.sv
// Result back: checks a captured packet and registers its result item.
module ipl4hp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ipl4hp_pkg::pkt_rec_type       head,
   input  ipl4hp_pkg::queue_status_type  q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ipl4hp_pkg::result_type        result
);

   ipl4hp_pkg::result_type          result_ff, result_in;
   logic                            valid_ff, valid_in;
   logic [ipl4hp_pkg::LEN_W-1:0]    hdr_len;
   logic [ipl4hp_pkg::LEN_W-1:0]    avail;
   logic [ipl4hp_pkg::LEN_W-1:0]    thl;
   logic                            is_tcp, is_udp, is_icmp;

   assign hdr_len = ipl4hp_pkg::LEN_W'({head.version_ihl[3:0], 2'b00});
   assign avail   = head.len - hdr_len;
   assign is_tcp  = (head.proto == ipl4hp_pkg::PROTO_TCP);
   assign is_udp  = (head.proto == ipl4hp_pkg::PROTO_UDP);
   assign is_icmp = (head.proto == ipl4hp_pkg::PROTO_ICMP);
   assign thl     = is_tcp ? ipl4hp_pkg::LEN_W'({head.data_offset, 2'b00})
                           : ipl4hp_pkg::LEN_W'(ipl4hp_pkg::SMALL_HDR);

   // Status checks in priority order, then the fields that apply.
   always_comb begin
      result_in = '0;
      if (head.len < ipl4hp_pkg::IP_MIN_HDR) begin
         result_in.status = ipl4hp_pkg::STATUS_TOO_SHORT;
      end else if (head.version_ihl[7:4] != ipl4hp_pkg::IP_VERSION) begin
         result_in.status = ipl4hp_pkg::STATUS_BAD_VERSION;
      end else if (hdr_len < ipl4hp_pkg::IP_MIN_HDR || hdr_len > head.len) begin
         result_in.status = ipl4hp_pkg::STATUS_BAD_IHL;
      end else begin
         result_in.src_addr     = head.src_addr;
         result_in.dst_addr     = head.dst_addr;
         result_in.protocol_num = head.proto;
         if (head.frag_word[13:0] != '0) begin
            result_in.status = ipl4hp_pkg::STATUS_FRAGMENT;
         end else if (!is_tcp && !is_udp && !is_icmp) begin
            result_in.status = ipl4hp_pkg::STATUS_UNSUPPORTED;
         end else if ((is_tcp && (avail < ipl4hp_pkg::TCP_MIN_HDR || thl > avail)) ||
                      (!is_tcp && avail < ipl4hp_pkg::LEN_W'(ipl4hp_pkg::SMALL_HDR))) begin
            result_in.status = ipl4hp_pkg::STATUS_TOO_SHORT;
         end else begin
            result_in.status = ipl4hp_pkg::STATUS_OK;
            if (is_icmp) begin
               result_in.icmp_type_code = head.port_a;
            end else begin
               result_in.sport = head.port_a;
               result_in.dport = head.port_b;
            end
            if (is_tcp) begin
               result_in.tcp_flag_bits = head.flags;
               result_in.seq_num       = head.seq;
               result_in.ack_num       = head.ack;
            end
            result_in.payload_offset = hdr_len + thl;
            result_in.payload_length = avail - thl;
         end
      end
   end

   // Output register: reloads when a packet is queued and it is empty or its item is being taken.
   assign pop       = q_status.not_empty && (!valid_ff || rsp_ready);
   assign valid_in  = pop || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign result    = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   // A failed packet never reports transport fields.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.status != ipl4hp_pkg::STATUS_OK) |->
      (result_ff.sport == '0 && result_ff.seq_num == '0 &&
       result_ff.payload_offset == '0 && result_ff.icmp_type_code == '0))
      else $error("back: transport fields set on a failed packet");

   // Packets rejected before the addresses are copied report no addresses.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (result_ff.status == ipl4hp_pkg::STATUS_BAD_VERSION ||
                    result_ff.status == ipl4hp_pkg::STATUS_BAD_IHL)) |->
      (result_ff.src_addr == '0 && result_ff.dst_addr == '0 && result_ff.protocol_num == '0))
      else $error("back: addresses set on a header error");

   // A waiting result item holds still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(result_ff)))
      else $error("back: waiting result item changed");

endmodule

FILE: design/ipv4_l4_header_parser_top.sv
// Top level of the IPv4 header parser with TCP, UDP and ICMP field extraction.
//
//   Channel   Direction  Handshake              Item
//   req_      in         req_valid/req_ready    one packet byte and a last-byte mark
//   rsp_      out        rsp_valid/rsp_ready    one parse result per packet
//
// One byte is accepted per clock while req_ready is high.
// A packet is written into the queue when its last byte is taken, then moves into the
// output register, raising rsp_valid, once that register is empty or its result is taken.
// Reset is synchronous and clears the byte counter, the queue and the output valid.
// A stalled output fills the output register and the two-entry packet queue; req_ready
// then drops for every byte and rises again in the cycle after a result is taken.
module ipv4_l4_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr,
   output logic [7:0]  rsp_protocol_num,
   output logic [15:0] rsp_sport,
   output logic [15:0] rsp_dport,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [31:0] rsp_seq_num,
   output logic [31:0] rsp_ack_num,
   output logic [15:0] rsp_icmp_type_code,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length
);

   ipl4hp_pkg::queue_status_type q_status;
   ipl4hp_pkg::pkt_rec_type      push_data;
   ipl4hp_pkg::pkt_rec_type      head;
   ipl4hp_pkg::result_type       result;
   logic                         push;
   logic                         pop;

   ipl4hp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   ipl4hp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   ipl4hp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .result    (result)
   );

   // Break the result item out onto its ports.
   assign rsp_status         = result.status;
   assign rsp_src_addr       = result.src_addr;
   assign rsp_dst_addr       = result.dst_addr;
   assign rsp_protocol_num   = result.protocol_num;
   assign rsp_sport          = result.sport;
   assign rsp_dport          = result.dport;
   assign rsp_tcp_flag_bits  = result.tcp_flag_bits;
   assign rsp_seq_num        = result.seq_num;
   assign rsp_ack_num        = result.ack_num;
   assign rsp_icmp_type_code = result.icmp_type_code;
   assign rsp_payload_offset = result.payload_offset;
   assign rsp_payload_length = result.payload_length;

endmodule

FILE: test/ipv4_l4_header_parser_top_tb.sv
// Testbench for the IPv4 header parser: byte-stream stimulus, field-level result checks.
`timescale 1ns / 1ps

module ipv4_l4_header_parser_top_tb;

   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS  = 10;

   // Header values used by the stimulus.
   localparam logic [7:0]  PROTO_OTHER = 8'd50;
   localparam logic [15:0] FRAG_DF     = 16'h4000;
   localparam logic [15:0] FRAG_MF     = 16'h2000;
   localparam logic [15:0] FRAG_OFFSET = 16'h1FFF;

   // Background content of packet bytes not set by a header field.
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   // Tracks the parser state per byte and holds the results still to come.
   class header_scoreboard;
      ipl4hp_pkg::result_type expected_q[$];
      int unsigned mismatches;
      int unsigned byte_cnt;
      logic [7:0]  ver_ihl;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [3:0]  tcp_doff;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         byte_cnt = 0;
         ver_ihl  = '0;
         frag     = '0;
         proto    = '0;
         src      = '0;
         dst      = '0;
         port_a   = '0;
         port_b   = '0;
         flags    = '0;
         seq      = '0;
         ack      = '0;
         tcp_doff = '0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Stores one byte at its position in the IPv4 or transport header.
      function void capture_byte(int unsigned pos, logic [7:0] b);
         logic [7:0]  vih;
         int unsigned hl;
         int unsigned rel;
         vih = (pos == 0) ? b : ver_ihl;
         hl = vih[3:0] * 4;
         if (pos == ipl4hp_pkg::POS_VER_IHL) ver_ihl = b;
         else if (pos == ipl4hp_pkg::POS_FRAG_HI || pos == ipl4hp_pkg::POS_FRAG_LO)
            frag = {frag[7:0], b};
         else if (pos == ipl4hp_pkg::POS_PROTO) proto = b;
         else if (pos >= ipl4hp_pkg::POS_SRC_LO && pos <= ipl4hp_pkg::POS_SRC_HI)
            src = {src[23:0], b};
         else if (pos >= ipl4hp_pkg::POS_DST_LO && pos <= ipl4hp_pkg::POS_DST_HI)
            dst = {dst[23:0], b};

         // The transport header starts after the IPv4 header, never before byte 20.
         if (pos >= hl && pos >= ipl4hp_pkg::IP_MIN_HDR) begin
            rel = pos - hl;
            if (rel <= ipl4hp_pkg::REL_PORT_A_LAST) port_a = {port_a[7:0], b};
            else if (rel <= ipl4hp_pkg::REL_PORT_B_LAST) port_b = {port_b[7:0], b};
            else if (rel <= ipl4hp_pkg::REL_SEQ_LAST) seq = {seq[23:0], b};
            else if (rel <= ipl4hp_pkg::REL_ACK_LAST) ack = {ack[23:0], b};
            else if (rel == ipl4hp_pkg::REL_DOFF) tcp_doff = b[7:4];
            else if (rel == ipl4hp_pkg::REL_FLAGS) flags = b;
         end
      endfunction

      // Works out the result of a packet of len bytes from the captured fields.
      function ipl4hp_pkg::result_type parse_result(int unsigned len);
         ipl4hp_pkg::result_type r;
         int unsigned hl;
         int unsigned avail;
         int unsigned thl;
         r = '0;
         hl = ver_ihl[3:0] * 4;
         if (len < ipl4hp_pkg::IP_MIN_HDR) begin
            r.status = ipl4hp_pkg::STATUS_TOO_SHORT;
            return r;
         end
         if (ver_ihl[7:4] != ipl4hp_pkg::IP_VERSION) begin
            r.status = ipl4hp_pkg::STATUS_BAD_VERSION;
            return r;
         end
         if (hl < ipl4hp_pkg::IP_MIN_HDR || hl > len) begin
            r.status = ipl4hp_pkg::STATUS_BAD_IHL;
            return r;
         end
         r.src_addr     = src;
         r.dst_addr     = dst;
         r.protocol_num = proto;
         if (frag[13] || frag[12:0] != 0) begin
            r.status = ipl4hp_pkg::STATUS_FRAGMENT;
            return r;
         end

         // The transport header must fit in what is left of the packet.
         avail = len - hl;
         if (proto == ipl4hp_pkg::PROTO_TCP) begin
            thl = tcp_doff * 4;
            r.status = (avail < ipl4hp_pkg::TCP_MIN_HDR || thl > avail) ?
                       ipl4hp_pkg::STATUS_TOO_SHORT : ipl4hp_pkg::STATUS_OK;
         end else if (proto == ipl4hp_pkg::PROTO_UDP || proto == ipl4hp_pkg::PROTO_ICMP) begin
            thl = ipl4hp_pkg::SMALL_HDR;
            r.status = (avail < ipl4hp_pkg::SMALL_HDR) ?
                       ipl4hp_pkg::STATUS_TOO_SHORT : ipl4hp_pkg::STATUS_OK;
         end else begin
            r.status = ipl4hp_pkg::STATUS_UNSUPPORTED;
            return r;
         end
         if (r.status != ipl4hp_pkg::STATUS_OK) return r;

         if (proto == ipl4hp_pkg::PROTO_TCP) begin
            r.sport         = port_a;
            r.dport         = port_b;
            r.tcp_flag_bits = flags;
            r.seq_num       = seq;
            r.ack_num       = ack;
         end else if (proto == ipl4hp_pkg::PROTO_UDP) begin
            r.sport = port_a;
            r.dport = port_b;
         end else begin
            r.icmp_type_code = port_a;
         end
         r.payload_offset = 16'(hl + thl);
         r.payload_length = 16'(len - hl - thl);
         return r;
      endfunction

      // Notes one accepted input item; the last byte of a packet yields a result.
      function void note_byte(logic [7:0] b, logic last_flag);
         int unsigned pos;
         pos = byte_cnt;
         if (pos < ipl4hp_pkg::MAX_LEN) begin
            capture_byte(pos, b);
            byte_cnt = pos + 1;
         end
         if (last_flag) begin
            expected_q.push_back(parse_result(byte_cnt));
            clear();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      // Checks one accepted result against the oldest expectation.
      function void check_result(ipl4hp_pkg::result_type got);
         ipl4hp_pkg::result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with no packet pending, status %0d", $time, got.status);
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("src_addr", want.src_addr, got.src_addr);
         compare_field("dst_addr", want.dst_addr, got.dst_addr);
         compare_field("protocol_num", want.protocol_num, got.protocol_num);
         compare_field("sport", want.sport, got.sport);
         compare_field("dport", want.dport, got.dport);
         compare_field("tcp_flag_bits", want.tcp_flag_bits, got.tcp_flag_bits);
         compare_field("seq_num", want.seq_num, got.seq_num);
         compare_field("ack_num", want.ack_num, got.ack_num);
         compare_field("icmp_type_code", want.icmp_type_code, got.icmp_type_code);
         compare_field("payload_offset", want.payload_offset, got.payload_offset);
         compare_field("payload_length", want.payload_length, got.payload_length);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_src_addr;
   logic [31:0] rsp_dst_addr;
   logic [7:0]  rsp_protocol_num;
   logic [15:0] rsp_sport;
   logic [15:0] rsp_dport;
   logic [7:0]  rsp_tcp_flag_bits;
   logic [31:0] rsp_seq_num;
   logic [31:0] rsp_ack_num;
   logic [15:0] rsp_icmp_type_code;
   logic [15:0] rsp_payload_offset;
   logic [15:0] rsp_payload_length;

   header_scoreboard sb;
   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_idle_pct = 0;
   int unsigned      stall_cycles = 0;

   ipv4_l4_header_parser_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_src_addr       (rsp_src_addr),
      .rsp_dst_addr       (rsp_dst_addr),
      .rsp_protocol_num   (rsp_protocol_num),
      .rsp_sport          (rsp_sport),
      .rsp_dport          (rsp_dport),
      .rsp_tcp_flag_bits  (rsp_tcp_flag_bits),
      .rsp_seq_num        (rsp_seq_num),
      .rsp_ack_num        (rsp_ack_num),
      .rsp_icmp_type_code (rsp_icmp_type_code),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random; its ready changes on the falling edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
   end

   function automatic ipl4hp_pkg::result_type read_result();
      ipl4hp_pkg::result_type r;
      r.status         = rsp_status;
      r.src_addr       = rsp_src_addr;
      r.dst_addr       = rsp_dst_addr;
      r.protocol_num   = rsp_protocol_num;
      r.sport          = rsp_sport;
      r.dport          = rsp_dport;
      r.tcp_flag_bits  = rsp_tcp_flag_bits;
      r.seq_num        = rsp_seq_num;
      r.ack_num        = rsp_ack_num;
      r.icmp_type_code = rsp_icmp_type_code;
      r.payload_offset = rsp_payload_offset;
      r.payload_length = rsp_payload_length;
      return r;
   endfunction

   // Results are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(read_result());
   end

   // Ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drives one item from a falling edge and returns at the falling edge after it is taken.
   task automatic send_byte(input logic [7:0] b, input logic last_flag);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      req_last_byte = last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, last_flag);
      @(negedge clock);
   endtask

   // Builds a packet around the given header values and sends it byte by byte.
   task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [15:0] frag, input logic [7:0] proto,
                              input logic [3:0] doff, input int unsigned len,
                              input fill_kind_type fill);
      logic [7:0]  bytes[$];
      int unsigned base;
      int unsigned i;
      for (i = 0; i < len; i++) begin
         case (fill)
            FILL_ONES:  bytes.push_back(8'hFF);
            FILL_ZEROS: bytes.push_back(8'h00);
            default:    bytes.push_back(8'($urandom));
         endcase
      end
      base = (ihl * 4 > ipl4hp_pkg::IP_MIN_HDR) ? ihl * 4 : ipl4hp_pkg::IP_MIN_HDR;
      bytes[0] = {ver, ihl};
      if (len > ipl4hp_pkg::POS_FRAG_HI) bytes[ipl4hp_pkg::POS_FRAG_HI] = frag[15:8];
      if (len > ipl4hp_pkg::POS_FRAG_LO) bytes[ipl4hp_pkg::POS_FRAG_LO] = frag[7:0];
      if (len > ipl4hp_pkg::POS_PROTO) bytes[ipl4hp_pkg::POS_PROTO] = proto;
      if (len > base + ipl4hp_pkg::REL_DOFF)
         bytes[base + ipl4hp_pkg::REL_DOFF] = {doff, bytes[base + ipl4hp_pkg::REL_DOFF][3:0]};
      for (i = 0; i < len; i++) send_byte(bytes[i], i == len - 1);
   endtask

   // Mostly well-formed packets with random content, the rest any header and length.
   task automatic send_random_packets(input int unsigned byte_goal, input int unsigned pkt_goal);
      int unsigned bytes_out;
      int unsigned pkts_out;
      int unsigned thl;
      int unsigned tlen;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [15:0] frag;
      logic [7:0]  proto;
      bytes_out = 0;
      pkts_out = 0;
      while (bytes_out < byte_goal || pkts_out < pkt_goal) begin
         doff = 4'($urandom);
         if ($urandom_range(99) < 80) begin
            ver = ipl4hp_pkg::IP_VERSION;
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
            frag = ($urandom_range(1) == 0) ? FRAG_DF : 16'h0000;
            case ($urandom_range(2))
               0:       proto = ipl4hp_pkg::PROTO_TCP;
               1:       proto = ipl4hp_pkg::PROTO_UDP;
               default: proto = ipl4hp_pkg::PROTO_ICMP;
            endcase
            if ($urandom_range(3) != 0) doff = 4'd5 + 4'($urandom_range(3));
            if (proto != ipl4hp_pkg::PROTO_TCP) thl = ipl4hp_pkg::SMALL_HDR;
            else thl = (doff * 4 < ipl4hp_pkg::TCP_MIN_HDR) ? ipl4hp_pkg::TCP_MIN_HDR : doff * 4;
            tlen = ihl * 4 + thl + $urandom_range(24);
            // Now and then shorten the packet, which can cut into the transport header.
            if ($urandom_range(9) == 0) tlen = tlen - $urandom_range(4, 1);
         end else begin
            ver = ($urandom_range(3) == 0) ? 4'($urandom) : ipl4hp_pkg::IP_VERSION;
            ihl = 4'($urandom);
            frag = ($urandom_range(1) == 0) ? 16'($urandom) : 16'h0000;
            proto = ($urandom_range(1) == 0) ? 8'($urandom) : ipl4hp_pkg::PROTO_TCP;
            tlen = $urandom_range(90, 1);
         end
         send_packet(ver, ihl, frag, proto, doff, tlen, FILL_RANDOM);
         bytes_out += tlen;
         pkts_out++;
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed packets: every status and the field extremes.
      sender_idle_pct = 23;
      receiver_idle_pct = 82;
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd5, 1,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 19,
                  FILL_RANDOM);
      send_packet(4'd6, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 28, FILL_RANDOM);
      send_packet(4'hF, 4'hF, 16'hFFFF, 8'hFF, 4'hF, 20, FILL_ONES);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd4, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 28,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd15, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 40,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, FRAG_MF, ipl4hp_pkg::PROTO_UDP, 4'd5, 28,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, FRAG_OFFSET, ipl4hp_pkg::PROTO_UDP, 4'd5, 28,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, FRAG_DF, ipl4hp_pkg::PROTO_UDP, 4'd5, 28,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, PROTO_OTHER, 4'd5, 40, FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, 8'h00, 4'd5, 20, FILL_ZEROS);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd5, 39,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd15, 60,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd15, 80,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd5, 40,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd0, 50,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd6, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd6, 72,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd15, 16'h0000, ipl4hp_pkg::PROTO_TCP, 4'd15, 140,
                  FILL_ONES);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 27,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_UDP, 4'd5, 28,
                  FILL_ZEROS);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_ICMP, 4'd5, 36,
                  FILL_RANDOM);
      send_packet(ipl4hp_pkg::IP_VERSION, 4'd5, 16'h0000, ipl4hp_pkg::PROTO_ICMP, 4'd5, 27,
                  FILL_RANDOM);

      // Random packets under three idling patterns.
      send_random_packets(100, 1);
      sender_idle_pct = 82;
      receiver_idle_pct = 23;
      send_random_packets(100, 1);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_random_packets(100, 1);
      req_valid = 1'b0;

      // Let the last results drain, then watch for stray output before the verdict.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
design/ipl4hp_pkg.sv
design/ipl4hp_front.sv
design/ipl4hp_queue.sv
design/ipl4hp_back.sv
design/ipv4_l4_header_parser_top.sv
test/ipv4_l4_header_parser_top_tb.sv
